// ===== design/watmf_pkg.sv =====
// Shared constants for the wrap-aware trimmed mean filter.
package watmf_pkg;

    localparam int DATA_W = 16;
    localparam logic [DATA_W-1:0] GAP_THRESHOLD_RESET = 16'd23040;

    // Division of a short length by three: (len * 171) >> 9 is exact up to len = 511.
    localparam int TRIM_MUL_W = 8;
    localparam logic [TRIM_MUL_W-1:0] TRIM_MUL = 8'd171;
    localparam int TRIM_SHIFT = 9;

endpackage

// ===== design/watmf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module watmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/watmf_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module watmf_div #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic             ge;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/wrap_aware_trimmed_mean_filter.sv =====
// Top level: window memory, rank sort, gap scan, trimmed sum and division.
//
//  channel  | direction | handshake         | payload
//  s_       | in        | s_tvalid/s_tready | s_tdata = angle_sample
//  m_       | out       | m_tvalid/m_tready | m_tdata = filtered_angle, m_tuser = gap_found
//  cfg_     | in        | cfg_wr_en         | cfg_wr_data = gap_threshold
//
// The rank sort dominates the processing of a word: each window entry is compared
// against all others through the one window read port.
// Reset clears the window valid bits and the pointer and loads the reset threshold; no clearing pass.
// A finished word waits in the output register while the next word is accepted.
module wrap_aware_trimmed_mean_filter
    import watmf_pkg::*;
#(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // [15:0] angle_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [15:0] filtered_angle
    output logic        m_tuser,     // [0] gap_found
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    localparam int W   = WINDOW_DEPTH;
    localparam int AW  = $clog2(W);
    localparam int LW  = $clog2(W + 1);
    localparam int SW  = DATA_W + $clog2(W);
    localparam logic [AW-1:0] LAST = AW'(W - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_KEY  = 4'd1;
    localparam logic [3:0] S_KEYW = 4'd2;
    localparam logic [3:0] S_CMP  = 4'd3;
    localparam logic [3:0] S_CMPL = 4'd4;
    localparam logic [3:0] S_SC   = 4'd5;
    localparam logic [3:0] S_SCL  = 4'd6;
    localparam logic [3:0] S_TRIM = 4'd7;
    localparam logic [3:0] S_SUM  = 4'd8;
    localparam logic [3:0] S_SUML = 4'd9;
    localparam logic [3:0] S_DIV  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0]        state_reg, state_next;
    logic [DATA_W-1:0] thr_reg;
    logic [AW-1:0]     wptr_reg, wptr_next;
    logic [W-1:0]      valid_reg, valid_next;
    logic              rvalid_reg;
    logic [AW-1:0]     i_reg, i_next, j_reg, j_next, jp_reg, jp_next;
    logic [AW-1:0]     k_reg, k_next, kp_reg, kp_next, last_reg, last_next;
    logic [AW-1:0]     rank_reg, rank_next;
    logic              pend_reg, pend_next;
    logic signed [DATA_W-1:0] key_reg, key_next, prev_reg, prev_next;
    logic              gap_reg, gap_next;
    logic [AW-1:0]     start_reg, start_next;
    logic [LW-1:0]     len_reg, len_next, cnt_reg, cnt_next;
    logic signed [SW-1:0] acc_reg, acc_next, total;
    logic              neg_reg, neg_next;
    logic              mv_reg, mv_next;
    logic [DATA_W-1:0] mdata_reg, mdata_next;
    logic              muser_reg, muser_next;

    logic [AW-1:0]     win_raddr, srt_raddr;
    logic [DATA_W-1:0] win_q, srt_q;
    logic signed [DATA_W-1:0] win_v, srt_v;
    logic              s_acc, rank_inc, div_start, div_done;
    logic [AW-1:0]     rank_total;
    logic signed [DATA_W:0] diff;
    logic [AW:0]       lower, upper;
    logic [LW+TRIM_MUL_W-1:0] trim_prod;
    logic [LW-1:0]     trim;
    logic [SW-1:0]     quo, mag;
    logic [DATA_W-1:0] mean;

    assign s_tready = state_reg == S_IDLE;
    assign s_acc    = s_tvalid && s_tready;

    always_comb begin
        unique case (state_reg)
            S_KEY:   win_raddr = i_reg;
            S_KEYW:  win_raddr = '0;
            default: win_raddr = j_reg;
        endcase
    end
    assign srt_raddr = k_reg;

    watmf_ram #(.WIDTH(DATA_W), .DEPTH(W)) u_win (
        .aclk (aclk), .we (s_acc), .waddr (wptr_reg), .wdata (s_tdata),
        .raddr (win_raddr), .rdata (win_q)
    );

    watmf_ram #(.WIDTH(DATA_W), .DEPTH(W)) u_srt (
        .aclk (aclk), .we (state_reg == S_CMPL), .waddr (rank_total), .wdata (key_reg),
        .raddr (srt_raddr), .rdata (srt_q)
    );

    // Entries never written since reset read as zero.
    assign win_v = rvalid_reg ? signed'(win_q) : '0;
    assign srt_v = signed'(srt_q);

    // Ties are broken by window index, so the ranks form a permutation.
    assign rank_inc   = pend_reg && ((win_v < key_reg) || ((win_v == key_reg) && (jp_reg < i_reg)));
    assign rank_total = rank_reg + AW'(rank_inc);

    assign diff  = {srt_v[DATA_W-1], srt_v} - {prev_reg[DATA_W-1], prev_reg};
    assign lower = (AW+1)'(kp_reg);
    assign upper = (AW+1)'(W) - lower;

    assign trim_prod = len_reg * TRIM_MUL;
    assign trim      = LW'(trim_prod >> TRIM_SHIFT);

    assign total = acc_reg + SW'(srt_v);
    assign mag   = total[SW-1] ? SW'(-total) : SW'(total);

    watmf_div #(.NUM_W(SW), .DEN_W(LW)) u_div (
        .aclk (aclk), .aresetn (aresetn), .start (div_start), .dividend (mag),
        .divisor (cnt_reg), .done (div_done), .quotient (quo)
    );

    assign div_start = state_reg == S_SUML;
    assign mean      = neg_reg ? DATA_W'(-quo) : DATA_W'(quo);

    always_comb begin
        state_next = state_reg;
        wptr_next  = wptr_reg;
        valid_next = valid_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        jp_next    = jp_reg;
        k_next     = k_reg;
        kp_next    = kp_reg;
        last_next  = last_reg;
        rank_next  = rank_reg;
        pend_next  = pend_reg;
        key_next   = key_reg;
        prev_next  = prev_reg;
        gap_next   = gap_reg;
        start_next = start_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        mv_next    = mv_reg && !m_tready;
        mdata_next = mdata_reg;
        muser_next = muser_reg;

        unique case (state_reg) inside
            S_IDLE: begin
                if (s_acc) begin
                    valid_next[wptr_reg] = 1'b1;
                    wptr_next  = (wptr_reg == LAST) ? '0 : wptr_reg + 1'b1;
                    i_next     = '0;
                    state_next = S_KEY;
                end
            end
            S_KEY: begin
                rank_next  = '0;
                state_next = S_KEYW;
            end
            S_KEYW: begin
                key_next   = win_v;
                jp_next    = '0;
                j_next     = AW'(1);
                pend_next  = 1'b1;
                state_next = (W == 1) ? S_CMPL : S_CMP;
            end
            S_CMP: begin
                rank_next = rank_total;
                jp_next   = j_reg;
                j_next    = j_reg + 1'b1;
                if (j_reg == LAST) begin
                    state_next = S_CMPL;
                end
            end
            S_CMPL: begin
                pend_next = 1'b0;
                if (i_reg == LAST) begin
                    k_next     = '0;
                    gap_next   = 1'b0;
                    start_next = '0;
                    len_next   = LW'(W);
                    state_next = S_SC;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_KEY;
                end
            end
            S_SC, S_SCL: begin
                if (pend_reg) begin
                    prev_next = srt_v;
                    if (kp_reg != '0 && !gap_reg && $unsigned(diff) > {1'b0, thr_reg}) begin
                        gap_next = 1'b1;
                        // Keep the larger part; the lower one on a tie.
                        if (upper > lower) begin
                            start_next = kp_reg;
                            len_next   = LW'(upper);
                        end else begin
                            start_next = '0;
                            len_next   = LW'(lower);
                        end
                    end
                end
                if (state_reg == S_SC) begin
                    pend_next = 1'b1;
                    kp_next   = k_reg;
                    k_next    = k_reg + 1'b1;
                    if (k_reg == LAST) begin
                        state_next = S_SCL;
                    end
                end else begin
                    pend_next  = 1'b0;
                    state_next = S_TRIM;
                end
            end
            S_TRIM: begin
                cnt_next   = len_reg - (trim << 1);
                k_next     = AW'(start_reg + trim);
                last_next  = AW'(start_reg + len_reg - trim - 1'b1);
                acc_next   = '0;
                state_next = S_SUM;
            end
            S_SUM: begin
                if (pend_reg) begin
                    acc_next = total;
                end
                pend_next = 1'b1;
                k_next    = k_reg + 1'b1;
                if (k_reg == last_reg) begin
                    state_next = S_SUML;
                end
            end
            S_SUML: begin
                pend_next  = 1'b0;
                neg_next   = total[SW-1];
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    mdata_next = mean;
                    muser_next = gap_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            thr_reg   <= GAP_THRESHOLD_RESET;
            wptr_reg  <= '0;
            valid_reg <= '0;
            pend_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            wptr_reg  <= wptr_next;
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
            mv_reg    <= mv_next;
        end
        rvalid_reg <= valid_reg[win_raddr];
        i_reg      <= i_next;
        j_reg      <= j_next;
        jp_reg     <= jp_next;
        k_reg      <= k_next;
        kp_reg     <= kp_next;
        last_reg   <= last_next;
        rank_reg   <= rank_next;
        key_reg    <= key_next;
        prev_reg   <= prev_next;
        gap_reg    <= gap_next;
        start_reg  <= start_next;
        len_reg    <= len_next;
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        neg_reg    <= neg_next;
        mdata_reg  <= mdata_next;
        muser_reg  <= muser_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the wrap-aware trimmed mean filter: scoreboard class, drivers and checks.
`timescale 1ns / 1ps

module tb_top
    import watmf_pkg::*;
();

    localparam int DEPTH = 16;

    typedef struct packed {
        logic signed [15:0] angle;
        logic               gap;
    } filter_out_t;

    class mean_scoreboard;
        logic signed [15:0] window [DEPTH];
        int unsigned        wr_ptr;
        logic [15:0]        threshold;
        filter_out_t        pending [$];
        int                 errors;

        function void clear();
            foreach (window[i]) window[i] = '0;
            wr_ptr = 0;
            threshold = GAP_THRESHOLD_RESET;
            pending.delete();
            errors = 0;
        endfunction

        function void set_threshold(logic [15:0] value);
            threshold = value;
        endfunction

        // Computes the filtered angle for one accepted word and queues it.
        function void note_sample(logic signed [15:0] sample);
            int sorted [DEPTH];
            int key, j, start, len, lower, upper, trim, cnt, sum, mean;
            logic [31:0] diff;
            filter_out_t res;
            window[wr_ptr] = sample;
            wr_ptr = (wr_ptr + 1) % DEPTH;
            for (int i = 0; i < DEPTH; i++) sorted[i] = window[i];
            for (int i = 1; i < DEPTH; i++) begin
                key = sorted[i];
                j = i - 1;
                while (j >= 0 && sorted[j] > key) begin
                    sorted[j + 1] = sorted[j];
                    j--;
                end
                sorted[j + 1] = key;
            end
            start = 0;
            len = DEPTH;
            res.gap = 1'b0;
            for (int i = 0; i < DEPTH - 1; i++) begin
                diff = sorted[i + 1] - sorted[i];
                if (diff > {16'd0, threshold}) begin
                    lower = i + 1;
                    upper = DEPTH - lower;
                    res.gap = 1'b1;
                    if (upper > lower) begin
                        start = lower;
                        len = upper;
                    end else begin
                        len = lower;
                    end
                    break;
                end
            end
            trim = len / 3;
            cnt = len - 2 * trim;
            sum = 0;
            for (int i = trim; i < len - trim; i++) sum += sorted[start + i];
            mean = sum / cnt;
            res.angle = mean[15:0];
            pending.push_back(res);
        endfunction

        function void check_result(logic [15:0] angle, logic gap);
            filter_out_t exp_res;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word angle=%0d gap=%0b", $time,
                         $signed(angle), gap);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (angle !== exp_res.angle) begin
                $display("%0t: filtered_angle expected %0d actual %0d", $time,
                         exp_res.angle, $signed(angle));
                errors++;
            end
            if (gap !== exp_res.gap) begin
                $display("%0t: gap_found expected %0b actual %0b", $time, exp_res.gap, gap);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    mean_scoreboard board;
    int send_idle_pct;
    int recv_stall_pct;

    wrap_aware_trimmed_mean_filter #(.WINDOW_DEPTH(DEPTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #200ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: stalls at random and checks every accepted word.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Valid stays high after a word is taken, so back-to-back words need no gap;
    // every pause drops it first.
    task automatic send_sample(logic [15:0] value);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        board.note_sample(value);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_threshold(logic [15:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        board.set_threshold(value);
    endtask

    function automatic logic [15:0] random_angle();
        int r;
        r = $urandom_range(99);
        if (r < 8) return 16'($urandom);
        if (r < 55) return 16'($urandom_range(46080) - 23040);
        // Clusters near the wrap point on both sides.
        if (r < 78) return 16'(23040 - $urandom_range(1500));
        return 16'(-23040 + $urandom_range(1500));
    endfunction

    function automatic logic [15:0] random_threshold();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 16'd0;
        if (r == 1) return 16'd46080;
        if (r == 2) return 16'hFFFF;
        if (r == 3) return 16'($urandom);
        return 16'($urandom_range(46080));
    endfunction

    initial begin
        logic [15:0] directed [] = '{16'sd0, 16'sd23040, -16'sd23040, 16'h7FFF, 16'h8000,
            16'hFFFF, 16'd1, 16'sd22000, -16'sd22000, 16'sd23000, -16'sd23000, 16'sd100,
            -16'sd100, 16'h5555, 16'hAAAA, 16'sd23040, -16'sd23040, 16'sd12345};
        board = new();
        board.clear();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty window at reset threshold, then extremes.
        foreach (directed[i]) send_sample(directed[i]);
        write_threshold(16'd0);
        for (int i = 0; i < 4; i++) send_sample(directed[i]);
        write_threshold(16'hFFFF);
        for (int i = 0; i < 3; i++) send_sample(directed[i]);

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            write_threshold(phase == 0 ? 16'd46080 : random_threshold());
            for (int n = 0; n < 185; n++) begin
                send_sample(random_angle());
                // Hold off the sender until the pipeline is empty.
                if (n == 90) drain();
            end
        end

        drain();
        if (board.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
